### src/rmat_pkg.sv
// Package for the R-MAT edge generator: field widths, register indexes,
// reset values, controller states and the controller/datapath interface.
// No dependencies.
package rmat_pkg;

    // Fixed field widths.
    localparam int WORD_BITS      = 31;
    localparam int TRIAL_BITS     = 48;
    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_INDEX_BITS = 3;
    localparam int SCALE_REG_BITS = 6;
    localparam int DEGREE_BITS    = 16;
    localparam int VERTEX_BITS    = 32;

    // Register reset values.
    localparam int RST_WEIGHT_A = 57;
    localparam int RST_WEIGHT_B = 19;
    localparam int RST_WEIGHT_C = 19;
    localparam int RST_WEIGHT_D = 5;
    localparam int RST_SCALE    = 8;
    localparam int RST_DEGREE   = 16;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_WEIGHT_A   = 3'd0,
        CFG_WEIGHT_B   = 3'd1,
        CFG_WEIGHT_C   = 3'd2,
        CFG_WEIGHT_D   = 3'd3,
        CFG_SCALE      = 3'd4,
        CFG_DEGREE     = 3'd5,
        CFG_DROP_LOOPS = 3'd6,
        CFG_UNDIRECTED = 3'd7
    } t_cfg_index;

    // Result kinds.
    localparam logic KIND_EDGE = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_STEP,
        S_CHECK,
        S_EDGE,
        S_REV,
        S_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;      // latch the random word and start the remainder
        logic step;       // shift one quadrant bit into the vertex numbers
        logic load_edge;  // load the forward edge into the output register
        logic load_rev;   // load the reversed edge
        logic load_done;  // load the done marker and set the finished flag
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic finished;
        logic budget_met;  // completed trials reach the total
        logic div_done;
        logic trial_end;   // the current bit completes a trial
        logic keep_edge;   // the completed edge is not a dropped self-loop
        logic undirected;
        logic out_free;    // the output register can take a result
    } t_stat;

endpackage

### src/rmat_mod.sv
// Bit-serial remainder unit: reduces a random word modulo the weight sum,
// one dividend bit per cycle. Depends on rmat_pkg.
module rmat_mod #(
    parameter int SUM_W = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [rmat_pkg::WORD_BITS-1:0] i_word,
    input  logic [SUM_W-1:0]              i_sum,
    output logic                          o_busy,
    output logic [SUM_W-1:0]              o_rem
);
    import rmat_pkg::*;

    localparam int CNT_W = $clog2(WORD_BITS);

    logic               r_busy, n_busy;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [WORD_BITS-1:0] r_word, n_word;
    logic [SUM_W-1:0]   r_rem, n_rem;
    logic [SUM_W:0]     w_shifted;
    logic [SUM_W:0]     w_diff;

    // One restoring step: bring down the next bit and subtract if it fits.
    assign w_shifted = {r_rem, r_word[WORD_BITS-1]};
    assign w_diff    = w_shifted - {1'b0, i_sum};

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_word = r_word;
        n_rem  = r_rem;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_word = i_word;
            n_rem  = '0;
        end else if (r_busy) begin
            n_word = r_word << 1;
            n_cnt  = r_cnt + 1'b1;
            if (i_sum == '0) begin
                // A zero weight sum gives a roll of zero.
                n_rem = '0;
            end else if (w_shifted >= {1'b0, i_sum}) begin
                n_rem = w_diff[SUM_W-1:0];
            end else begin
                n_rem = w_shifted[SUM_W-1:0];
            end
            if (r_cnt == CNT_W'(WORD_BITS - 1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
        r_cnt  <= n_cnt;
        r_word <= n_word;
        r_rem  <= n_rem;
    end

    assign o_busy = r_busy;
    assign o_rem  = r_rem;

endmodule

### src/rmat_ctrl.sv
// Controller state machine of the R-MAT edge generator: sequences the
// remainder, the bit step and the emission of results. Depends on rmat_pkg.
module rmat_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  rmat_pkg::t_stat i_stat,
    output logic            o_in_ready,
    output rmat_pkg::t_cmd  o_cmd
);
    import rmat_pkg::*;

    t_state r_state, n_state;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && !i_stat.finished) begin
                    n_state = i_stat.budget_met ? S_DONE : S_DIV;
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                n_state = i_stat.trial_end ? S_CHECK : S_IDLE;
            end
            S_CHECK: begin
                if (i_stat.keep_edge) begin
                    n_state = S_EDGE;
                end else begin
                    n_state = i_stat.budget_met ? S_DONE : S_IDLE;
                end
            end
            S_EDGE: begin
                if (i_stat.out_free) begin
                    if (i_stat.undirected) begin
                        n_state = S_REV;
                    end else begin
                        n_state = i_stat.budget_met ? S_DONE : S_IDLE;
                    end
                end
            end
            S_REV: begin
                if (i_stat.out_free) begin
                    n_state = i_stat.budget_met ? S_DONE : S_IDLE;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Commands.
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.start = i_in_valid && !i_stat.finished && !i_stat.budget_met;
            end
            S_STEP: begin
                o_cmd.step = 1'b1;
            end
            S_EDGE: begin
                o_cmd.load_edge = i_stat.out_free;
            end
            S_REV: begin
                o_cmd.load_rev = i_stat.out_free;
            end
            S_DONE: begin
                o_cmd.load_done = i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### src/rmat_dpath.sv
// Datapath of the R-MAT edge generator: configuration registers, remainder
// unit, vertex shift registers, trial counter and output register.
// Depends on rmat_pkg and rmat_mod.
module rmat_dpath #(
    parameter int MAX_SCALE   = 32,
    parameter int WEIGHT_BITS = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_valid,
    input  logic [rmat_pkg::CFG_INDEX_BITS-1:0]   i_cfg_index,
    input  logic [rmat_pkg::CFG_DATA_BITS-1:0]    i_cfg_data,
    input  logic [rmat_pkg::WORD_BITS-1:0]        i_word,
    input  logic                                  i_out_ready,
    input  rmat_pkg::t_cmd                        i_cmd,
    output rmat_pkg::t_stat                       o_stat,
    output logic                                  o_out_valid,
    output logic                                  o_out_kind,
    output logic [rmat_pkg::VERTEX_BITS-1:0]      o_out_src,
    output logic [rmat_pkg::VERTEX_BITS-1:0]      o_out_dst,
    output logic                                  o_out_last
);
    import rmat_pkg::*;

    localparam int SUM_W = WEIGHT_BITS + 2;
    localparam int BC_W  = $clog2(MAX_SCALE + 1);

    // Configuration registers.
    logic [WEIGHT_BITS-1:0]    r_weight_a, r_weight_b, r_weight_c, r_weight_d;
    logic [SCALE_REG_BITS-1:0] r_scale;
    logic [DEGREE_BITS-1:0]    r_degree;
    logic                      r_drop_loops, r_undirected;

    // Trial state.
    logic [BC_W-1:0]       r_bit_count;
    logic [MAX_SCALE-1:0]  r_part_src, r_part_dst;
    logic [MAX_SCALE-1:0]  r_edge_src, r_edge_dst;
    logic [TRIAL_BITS-1:0] r_trials;
    logic                  r_finished;

    // Output register.
    logic                   r_out_valid, r_out_kind, r_out_last;
    logic [VERTEX_BITS-1:0] r_out_src, r_out_dst;

    logic [SUM_W-1:0]      w_ta, w_tb, w_tc, w_sum, w_roll;
    logic                  w_div_busy;
    logic [BC_W-1:0]       w_eff_scale, w_bit_next;
    logic [TRIAL_BITS-1:0] w_total;
    logic                  w_src_bit, w_dst_bit, w_trial_end, w_budget_met, w_out_free;
    logic [MAX_SCALE-1:0]  w_new_src, w_new_dst;

    // Configuration writes; unknown indexes cannot occur at this index width.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight_a   <= WEIGHT_BITS'(RST_WEIGHT_A);
            r_weight_b   <= WEIGHT_BITS'(RST_WEIGHT_B);
            r_weight_c   <= WEIGHT_BITS'(RST_WEIGHT_C);
            r_weight_d   <= WEIGHT_BITS'(RST_WEIGHT_D);
            r_scale      <= SCALE_REG_BITS'(RST_SCALE);
            r_degree     <= DEGREE_BITS'(RST_DEGREE);
            r_drop_loops <= 1'b0;
            r_undirected <= 1'b0;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_WEIGHT_A:   r_weight_a   <= i_cfg_data[WEIGHT_BITS-1:0];
                CFG_WEIGHT_B:   r_weight_b   <= i_cfg_data[WEIGHT_BITS-1:0];
                CFG_WEIGHT_C:   r_weight_c   <= i_cfg_data[WEIGHT_BITS-1:0];
                CFG_WEIGHT_D:   r_weight_d   <= i_cfg_data[WEIGHT_BITS-1:0];
                CFG_SCALE:      r_scale      <= i_cfg_data[SCALE_REG_BITS-1:0];
                CFG_DEGREE:     r_degree     <= i_cfg_data[DEGREE_BITS-1:0];
                CFG_DROP_LOOPS: r_drop_loops <= i_cfg_data[0];
                CFG_UNDIRECTED: r_undirected <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Cumulative quadrant thresholds and the weight sum.
    assign w_ta  = SUM_W'(r_weight_a);
    assign w_tb  = w_ta + SUM_W'(r_weight_b);
    assign w_tc  = w_tb + SUM_W'(r_weight_c);
    assign w_sum = w_tc + SUM_W'(r_weight_d);

    rmat_mod #(
        .SUM_W (SUM_W)
    ) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.start),
        .i_word  (i_word),
        .i_sum   (w_sum),
        .o_busy  (w_div_busy),
        .o_rem   (w_roll)
    );

    // Effective scale: zero counts as one, values above the maximum clamp.
    always_comb begin
        if (r_scale == '0) begin
            w_eff_scale = BC_W'(1);
        end else if (r_scale > SCALE_REG_BITS'(MAX_SCALE)) begin
            w_eff_scale = BC_W'(MAX_SCALE);
        end else begin
            w_eff_scale = BC_W'(r_scale);
        end
    end

    // Trial budget is the degree times half the vertex count.
    assign w_total      = TRIAL_BITS'(r_degree) << (w_eff_scale - 1'b1);
    assign w_budget_met = r_trials >= w_total;

    // Quadrant choice from the roll.
    always_comb begin
        w_src_bit = 1'b0;
        w_dst_bit = 1'b0;
        if (w_roll >= w_tc) begin
            w_src_bit = 1'b1;
            w_dst_bit = 1'b1;
        end else if (w_roll >= w_tb) begin
            w_src_bit = 1'b1;
        end else if (w_roll >= w_ta) begin
            w_dst_bit = 1'b1;
        end
    end

    assign w_new_src   = (r_part_src << 1) | MAX_SCALE'(w_src_bit);
    assign w_new_dst   = (r_part_dst << 1) | MAX_SCALE'(w_dst_bit);
    assign w_bit_next  = r_bit_count + 1'b1;
    assign w_trial_end = w_bit_next >= w_eff_scale;

    // Trial state update on each bit step.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_count <= '0;
            r_part_src  <= '0;
            r_part_dst  <= '0;
            r_trials    <= '0;
        end else if (i_cmd.step) begin
            if (w_trial_end) begin
                r_bit_count <= '0;
                r_part_src  <= '0;
                r_part_dst  <= '0;
                r_trials    <= r_trials + 1'b1;
            end else begin
                r_bit_count <= w_bit_next;
                r_part_src  <= w_new_src;
                r_part_dst  <= w_new_dst;
            end
        end
    end

    // The completed edge waits here while its results go out.
    always_ff @(posedge i_clk) begin
        if (i_cmd.step && w_trial_end) begin
            r_edge_src <= w_new_src;
            r_edge_dst <= w_new_dst;
        end
    end

    // Output register: loads when empty or being taken.
    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_finished  <= 1'b0;
        end else begin
            if (i_cmd.load_edge || i_cmd.load_rev || i_cmd.load_done) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.load_done) begin
                r_finished <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_edge) begin
            r_out_kind <= KIND_EDGE;
            r_out_src  <= VERTEX_BITS'(r_edge_src);
            r_out_dst  <= VERTEX_BITS'(r_edge_dst);
            r_out_last <= !r_undirected && !w_budget_met;
        end else if (i_cmd.load_rev) begin
            r_out_kind <= KIND_EDGE;
            r_out_src  <= VERTEX_BITS'(r_edge_dst);
            r_out_dst  <= VERTEX_BITS'(r_edge_src);
            r_out_last <= !w_budget_met;
        end else if (i_cmd.load_done) begin
            r_out_kind <= KIND_DONE;
            r_out_src  <= '0;
            r_out_dst  <= '0;
            r_out_last <= 1'b1;
        end
    end

    // Status to the controller.
    always_comb begin
        o_stat.finished   = r_finished;
        o_stat.budget_met = w_budget_met;
        o_stat.div_done   = !w_div_busy;
        o_stat.trial_end  = w_trial_end;
        o_stat.keep_edge  = !(r_drop_loops && (r_edge_src == r_edge_dst));
        o_stat.undirected = r_undirected;
        o_stat.out_free   = w_out_free;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_kind  = r_out_kind;
    assign o_out_src   = r_out_src;
    assign o_out_dst   = r_out_dst;
    assign o_out_last  = r_out_last;

endmodule

### src/rmat_edge_generator_unit.sv
// Top level of the R-MAT edge generator: joins the controller and the
// datapath. Depends on rmat_pkg, rmat_ctrl and rmat_dpath.
//
// Each input item carries one random word. The word is reduced modulo the
// sum of the four quadrant weights by a bit-serial remainder unit, one bit
// per cycle, and the chosen quadrant shifts one bit into the source and
// destination vertex numbers. An item that does not complete a trial passes
// through acceptance, the remainder unit and the bit step before the next
// item can be accepted. An item that completes a trial adds the loop check
// and the loading of each result (up to three), plus any stalls on the
// output side. An item that arrives when the trial budget is already met
// loads only the done marker; once the done marker is loaded, items are
// accepted and dropped at one per cycle. One output register holds a result
// while the next item is accepted and worked on. Configuration writes are
// accepted in every cycle and take effect at once; write them only while
// idle.
module rmat_edge_generator_unit #(
    parameter int MAX_SCALE   = 32,
    parameter int WEIGHT_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input items.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [30:0] random_word, [31] zero
    // Result items.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,   // [31:0] source_vertex, [63:32] target_vertex
    output logic [0:0]  o_m_axis_tuser,   // [0] kind
    output logic        o_m_axis_tlast,   // last_of_item
    // Configuration writes.
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [rmat_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [rmat_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);
    import rmat_pkg::*;

    t_cmd                   w_cmd;
    t_stat                  w_stat;
    logic                   w_in_ready;
    logic                   w_out_kind;
    logic [VERTEX_BITS-1:0] w_out_src, w_out_dst;

    rmat_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_stat     (w_stat),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    rmat_dpath #(
        .MAX_SCALE   (MAX_SCALE),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_word      (i_s_axis_tdata[WORD_BITS-1:0]),
        .i_out_ready (i_m_axis_tready),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_kind  (w_out_kind),
        .o_out_src   (w_out_src),
        .o_out_dst   (w_out_dst),
        .o_out_last  (o_m_axis_tlast)
    );

    assign o_s_axis_tready   = w_in_ready;
    assign o_m_axis_tdata    = {w_out_dst, w_out_src};
    assign o_m_axis_tuser[0] = w_out_kind;
    assign o_cfg_ready       = 1'b1;

endmodule

### src/rmat_checker.sv
// Port-level checks for the R-MAT edge generator, bound to the top level.
// Depends on rmat_edge_generator_unit.
module rmat_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [63:0] o_m_axis_tdata,
    input logic [0:0]  o_m_axis_tuser,
    input logic        o_m_axis_tlast
);

    logic r_done_taken;

    // Remember that the done marker has left the block.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done_taken <= 1'b0;
        end else if (o_m_axis_tvalid && i_m_axis_tready && o_m_axis_tuser[0]) begin
            r_done_taken <= 1'b1;
        end
    end

    // A stalled result holds its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)
            && $stable(o_m_axis_tlast))
        else $error("stalled result changed");

    // The done marker always ends its item.
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[0] |-> o_m_axis_tlast)
        else $error("done marker without last flag");

    // The done marker carries no vertex numbers.
    a_done_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[0] |-> o_m_axis_tdata == 64'd0)
        else $error("done marker with nonzero vertices");

    // Nothing follows the done marker.
    a_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done_taken |-> !o_m_axis_tvalid)
        else $error("result after done marker");

endmodule

bind rmat_edge_generator_unit rmat_checker u_rmat_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

### test/tb_rmat_edge_generator_unit.sv
// Self-checking testbench for rmat_edge_generator_unit: a directed stimulus table, then
// random phases with several idle patterns, all results checked against a local predictor.
// Depends on rmat_pkg and the rmat_edge_generator_unit RTL.
module tb_rmat_edge_generator_unit;
    import rmat_pkg::*;

    localparam int SCALE_CAP   = 32;
    localparam int WEIGHT_W    = 8;
    localparam int CYCLE_LIMIT = 400000;
    // Longer than one item's trip through the remainder unit and bit step.
    localparam int SETTLE      = 48;

    // One result item as the block should send it.
    typedef struct packed {
        logic        kind;
        logic [31:0] src;
        logic [31:0] tgt;
        logic        last;
    } edge_rec_t;

    // One row of the directed stimulus: a register write or an input item,
    // the latter with an optional typed-in result (at most one edge).
    typedef struct packed {
        logic        is_cfg;
        t_cfg_index  idx;
        logic [15:0] val;
        logic [30:0] word;
        logic        typed;
        logic [1:0]  n_exp;
        logic [31:0] src;
        logic [31:0] tgt;
    } stim_row_t;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_s_axis_tvalid;
    logic                      o_s_axis_tready;
    logic [31:0]               i_s_axis_tdata;
    logic                      o_m_axis_tvalid;
    logic                      i_m_axis_tready;
    logic [63:0]               o_m_axis_tdata;
    logic [0:0]                o_m_axis_tuser;
    logic                      o_m_axis_tlast;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index;
    logic [CFG_DATA_BITS-1:0]  i_cfg_data;

    // Typed-in expectation that travels alongside the item being offered.
    logic        row_typed;
    logic [1:0]  row_n;
    logic [31:0] row_src;
    logic [31:0] row_tgt;

    // Predictor copy of the registers and the trial state.
    logic [7:0]  w_a, w_b, w_c, w_d;
    logic [5:0]  scale_reg;
    logic [15:0] degree;
    logic        drop_self, both_ways;
    logic [5:0]  bits_in;
    logic [31:0] part_src, part_tgt;
    logic [47:0] trials_done;
    logic        finished_flag;

    edge_rec_t edges_due[$];
    edge_rec_t fresh[$];

    int errors      = 0;
    int items_in    = 0;
    int results_ok  = 0;
    int dones_seen  = 0;
    int cycles      = 0;
    int send_pct    = 0;
    int stall_pct   = 0;

    rmat_edge_generator_unit #(
        .MAX_SCALE  (SCALE_CAP),
        .WEIGHT_BITS(WEIGHT_W)
    ) u_top (.*);

    // Clock, period 8.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Output side: stall at the current rate.
    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Run guard.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycles, edges_due.size());
            $display("rmat_edge_generator_unit: mismatch");
            $finish;
        end
    end

    task automatic flag_mismatch(input string what);
        errors++;
        if (errors <= 30) $display("ERROR at cycle %0d: %s", cycles, what);
    endtask

    // Advance the predictor by one input word; the results it causes land in fresh.
    function automatic void grow_edge(input logic [30:0] word);
        logic [9:0]  ta, tb, tc, wsum;
        logic [31:0] roll, s, t;
        logic [5:0]  lim;
        logic [63:0] budget;
        fresh.delete();
        lim = (scale_reg == 6'd0) ? 6'd1 :
              (scale_reg > 6'(SCALE_CAP)) ? 6'(SCALE_CAP) : scale_reg;
        budget = ((64'd1 << lim) * 64'(degree)) >> 1;
        if (finished_flag) return;
        // Budget already met: the word is not used and only the done marker goes out.
        if (trials_done >= budget[47:0]) begin
            finished_flag = 1'b1;
            fresh.push_back('{KIND_DONE, 32'd0, 32'd0, 1'b1});
            return;
        end
        ta   = 10'(w_a);
        tb   = ta + 10'(w_b);
        tc   = tb + 10'(w_c);
        wsum = tc + 10'(w_d);
        // With all weights zero the roll is zero and every threshold is zero,
        // so the top quadrant (both bits) wins.
        roll = (wsum == 10'd0) ? 32'd0 : {1'b0, word} % 32'(wsum);
        s = part_src << 1;
        t = part_tgt << 1;
        if (roll >= 32'(tc)) begin
            s[0] = 1'b1;
            t[0] = 1'b1;
        end else if (roll >= 32'(tb)) begin
            s[0] = 1'b1;
        end else if (roll >= 32'(ta)) begin
            t[0] = 1'b1;
        end
        part_src = s;
        part_tgt = t;
        bits_in  = bits_in + 6'd1;
        // A trial also ends here when the scale was lowered below the bits gathered.
        if (bits_in < lim) return;
        bits_in     = 6'd0;
        part_src    = 32'd0;
        part_tgt    = 32'd0;
        trials_done = trials_done + 48'd1;
        if (!(drop_self && s == t)) begin
            fresh.push_back('{KIND_EDGE, s, t, 1'b0});
            if (both_ways) fresh.push_back('{KIND_EDGE, t, s, 1'b0});
        end
        if (trials_done >= budget[47:0]) begin
            finished_flag = 1'b1;
            fresh.push_back('{KIND_DONE, 32'd0, 32'd0, 1'b0});
        end
        if (fresh.size() > 0) fresh[fresh.size()-1].last = 1'b1;
    endfunction

    // Watch all three channels: update the predictor and check results.
    always @(posedge i_clk) begin
        edge_rec_t want;
        edge_rec_t got;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_WEIGHT_A:   w_a       = i_cfg_data[7:0];
                    CFG_WEIGHT_B:   w_b       = i_cfg_data[7:0];
                    CFG_WEIGHT_C:   w_c       = i_cfg_data[7:0];
                    CFG_WEIGHT_D:   w_d       = i_cfg_data[7:0];
                    CFG_SCALE:      scale_reg = i_cfg_data[5:0];
                    CFG_DEGREE:     degree    = i_cfg_data[15:0];
                    CFG_DROP_LOOPS: drop_self = i_cfg_data[0];
                    CFG_UNDIRECTED: both_ways = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                items_in++;
                grow_edge(i_s_axis_tdata[30:0]);
                if (row_typed) begin
                    if (row_n != 2'd0) edges_due.push_back('{KIND_EDGE, row_src, row_tgt, 1'b1});
                end else begin
                    foreach (fresh[j]) edges_due.push_back(fresh[j]);
                end
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got = '{o_m_axis_tuser[0], o_m_axis_tdata[31:0], o_m_axis_tdata[63:32],
                        o_m_axis_tlast};
                if (edges_due.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result kind %0d %0d->%0d last %0d",
                                            got.kind, got.src, got.tgt, got.last));
                end else begin
                    want = edges_due.pop_front();
                    if (got.kind !== want.kind)
                        flag_mismatch($sformatf("kind %0d, expected %0d", got.kind, want.kind));
                    if (got.src !== want.src)
                        flag_mismatch($sformatf("source %0d, expected %0d", got.src, want.src));
                    if (got.tgt !== want.tgt)
                        flag_mismatch($sformatf("target %0d, expected %0d", got.tgt, want.tgt));
                    if (got.last !== want.last)
                        flag_mismatch($sformatf("last %0d, expected %0d", got.last, want.last));
                    if (got.kind === KIND_DONE) dones_seen++;
                    results_ok++;
                end
            end
        end
    end

    // Set the idle pattern of both sides.
    task automatic set_idle(input int mode);
        case (mode)
            0: begin send_pct = 0;  stall_pct = 0;  end
            1: begin send_pct = 56; stall_pct = 0;  end
            2: begin send_pct = 0;  stall_pct = 56; end
            default: begin send_pct = 20; stall_pct = 20; end
        endcase
    endtask

    // Offer one item and wait until it is taken. Valid stays high afterwards.
    task automatic push_word(input logic [30:0] w, input logic typed, input logic [1:0] n_exp,
                             input logic [31:0] s, input logic [31:0] t, input bit hold);
        int gap;
        gap = (send_pct > 0 && $urandom_range(99) < send_pct) ? $urandom_range(1, 45) : 0;
        i_cfg_valid <= 1'b0;
        if (gap > 0 || hold) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            // Hold back until every result owed so far has come out.
            if (hold) begin
                @(posedge i_clk);
                while (edges_due.size() != 0) @(posedge i_clk);
            end
        end
        i_s_axis_tdata  <= {1'b0, w};
        i_s_axis_tvalid <= 1'b1;
        row_typed       <= typed;
        row_n           <= n_exp;
        row_src         <= s;
        row_tgt         <= t;
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    // Write one register. Valid stays high until the next item lowers it.
    task automatic write_reg(input t_cfg_index idx, input logic [15:0] val);
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Let the block drain: all results out, then time for a silent item to finish.
    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (edges_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Random word: mostly uniform, some near the thresholds, some at the ends.
    function automatic logic [30:0] draw_word();
        int r;
        r = $urandom_range(9);
        if (r == 0) return 31'd0;
        if (r == 1) return 31'h7FFF_FFFF;
        if (r < 4) return 31'($urandom_range(0, 2047));
        return 31'($urandom);
    endfunction

    // Weight write data, with junk above the eight weight bits now and then.
    function automatic logic [15:0] draw_weight();
        int r;
        logic [7:0] w;
        r = $urandom_range(7);
        w = (r == 0) ? 8'd0 : (r == 1) ? 8'hFF : 8'($urandom);
        return {($urandom_range(3) == 0) ? 8'($urandom) : 8'd0, w};
    endfunction

    function automatic stim_row_t item_row(input logic [30:0] w);
        return '{1'b0, CFG_WEIGHT_A, 16'd0, w, 1'b0, 2'd0, 32'd0, 32'd0};
    endfunction

    function automatic stim_row_t typed_row(input logic [30:0] w, input logic [1:0] n,
                                            input logic [31:0] s, input logic [31:0] t);
        return '{1'b0, CFG_WEIGHT_A, 16'd0, w, 1'b1, n, s, t};
    endfunction

    function automatic stim_row_t cfg_row(input t_cfg_index idx, input logic [15:0] v);
        return '{1'b1, idx, v, 31'd0, 1'b0, 2'd0, 32'd0, 32'd0};
    endfunction

    initial begin
        stim_row_t   plan[$];
        stim_row_t   row;
        logic        was_cfg;
        int          pick;
        int          eff;
        int          final_deg;
        logic [5:0]  sc;
        logic [15:0] dg;

        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = 32'd0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = '0;
        i_cfg_data      = '0;
        row_typed       = 1'b0;
        row_n           = 2'd0;
        row_src         = 32'd0;
        row_tgt         = 32'd0;
        w_a             = 8'(RST_WEIGHT_A);
        w_b             = 8'(RST_WEIGHT_B);
        w_c             = 8'(RST_WEIGHT_C);
        w_d             = 8'(RST_WEIGHT_D);
        scale_reg       = 6'(RST_SCALE);
        degree          = 16'(RST_DEGREE);
        drop_self       = 1'b0;
        both_ways       = 1'b0;
        bits_in         = 6'd0;
        part_src        = 32'd0;
        part_tgt        = 32'd0;
        trials_done     = 48'd0;
        finished_flag   = 1'b0;

        plan = '{
            // Reset setup, scale 8: single bits give no result yet.
            typed_row(31'h7FFF_FFFF, 2'd0, 32'd0, 32'd0),
            typed_row(31'h0000_0000, 2'd0, 32'd0, 32'd0),
            item_row(31'h2AAA_AAAA),
            item_row(31'h5555_5555),
            item_row(31'h1234_5678),
            // Five bits are gathered; dropping the scale to 2 ends the trial on the next bit.
            cfg_row(CFG_DEGREE, 16'd1000),
            cfg_row(CFG_SCALE, 16'd2),
            item_row(31'h0000_0003),
            // One bit per trial and a single nonzero weight pick each quadrant in turn.
            cfg_row(CFG_SCALE, 16'd1),
            cfg_row(CFG_WEIGHT_A, 16'd0),
            cfg_row(CFG_WEIGHT_B, 16'd0),
            cfg_row(CFG_WEIGHT_C, 16'd0),
            cfg_row(CFG_WEIGHT_D, 16'hFF01),
            typed_row(31'h7FFF_FFFF, 2'd1, 32'd1, 32'd1),
            cfg_row(CFG_WEIGHT_D, 16'd0),
            cfg_row(CFG_WEIGHT_B, 16'd1),
            typed_row(31'h0000_0001, 2'd1, 32'd0, 32'd1),
            cfg_row(CFG_WEIGHT_B, 16'd0),
            cfg_row(CFG_WEIGHT_C, 16'd1),
            typed_row(31'h4000_0000, 2'd1, 32'd1, 32'd0),
            cfg_row(CFG_WEIGHT_C, 16'd0),
            cfg_row(CFG_WEIGHT_A, 16'd1),
            typed_row(31'h7FFF_FFFF, 2'd1, 32'd0, 32'd0),
            // All weights zero.
            cfg_row(CFG_WEIGHT_A, 16'd0),
            item_row(31'h0000_1234),
            // Largest weights, self-loops dropped; words on the first two thresholds and at the ends.
            cfg_row(CFG_WEIGHT_A, 16'd255),
            cfg_row(CFG_WEIGHT_B, 16'd255),
            cfg_row(CFG_WEIGHT_C, 16'd255),
            cfg_row(CFG_WEIGHT_D, 16'd255),
            cfg_row(CFG_DROP_LOOPS, 16'd1),
            item_row(31'd0),
            item_row(31'd1019),
            item_row(31'd255),
            item_row(31'd510),
            item_row(31'h7FFF_FFFF),
            // Undirected edges; a scale of zero counts as one.
            cfg_row(CFG_DROP_LOOPS, 16'd0),
            cfg_row(CFG_UNDIRECTED, 16'd1),
            cfg_row(CFG_SCALE, 16'd0),
            item_row(31'h0000_0300),
            item_row(31'h0000_01FF),
            // Scale above the cap counts as the cap; largest degree.
            cfg_row(CFG_SCALE, 16'd63),
            cfg_row(CFG_DEGREE, 16'hFFFF),
            cfg_row(CFG_WEIGHT_A, 16'd57),
            cfg_row(CFG_WEIGHT_B, 16'd19),
            cfg_row(CFG_WEIGHT_C, 16'd19),
            cfg_row(CFG_WEIGHT_D, 16'd5),
            item_row(31'h6DB6_DB6D),
            item_row(31'h1249_2492),
            item_row(31'h7FFF_FFFE)
        };

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table.
        set_idle(0);
        was_cfg = 1'b1;
        foreach (plan[k]) begin
            row = plan[k];
            if (row.is_cfg) begin
                if (!was_cfg) settle();
                write_reg(row.idx, row.val);
            end else begin
                push_word(row.word, row.typed, row.n_exp, row.src, row.tgt, 1'b0);
            end
            was_cfg = row.is_cfg;
        end

        // Random phases: fresh settings each time, small scales most often.
        for (int ph = 0; ph < 12; ph++) begin
            set_idle(ph % 4);
            settle();
            pick = $urandom_range(15);
            if (pick < 6)       sc = 6'd1;
            else if (pick < 9)  sc = 6'd2;
            else if (pick == 9) sc = 6'd0;
            else if (pick == 10) sc = 6'd3;
            else if (pick == 11) sc = 6'd4;
            else if (pick == 12) sc = 6'd63;
            else if (pick == 13) sc = 6'd32;
            else sc = 6'($urandom_range(5, 63));
            eff = (sc == 6'd0) ? 1 : (sc > 6'(SCALE_CAP)) ? SCALE_CAP : int'(sc);
            // Keep the trial budget far above what the run can use up.
            if (eff >= 12 && $urandom_range(3) == 0) dg = 16'd1;
            else if ($urandom_range(5) == 0)        dg = 16'hFFFF;
            else                                    dg = 16'($urandom_range(1000, 65535));
            write_reg(CFG_WEIGHT_A, draw_weight());
            write_reg(CFG_WEIGHT_B, draw_weight());
            write_reg(CFG_WEIGHT_C, draw_weight());
            write_reg(CFG_WEIGHT_D, draw_weight());
            write_reg(CFG_SCALE, {10'($urandom), sc});
            write_reg(CFG_DEGREE, dg);
            write_reg(CFG_DROP_LOOPS, {15'($urandom), 1'($urandom_range(1))});
            write_reg(CFG_UNDIRECTED, {15'($urandom), 1'($urandom_range(1))});
            for (int n = 0; n < 21; n++)
                push_word(draw_word(), 1'b0, 2'd0, 32'd0, 32'd0, $urandom_range(24) == 0);
        end

        // Closing phase: meet the trial budget, either on a trial or before any
        // trial, then check that later items and writes bring nothing out.
        set_idle(2);
        settle();
        write_reg(CFG_SCALE, 16'd1);
        write_reg(CFG_DROP_LOOPS, 16'd0);
        write_reg(CFG_UNDIRECTED, 16'd1);
        final_deg = ($urandom_range(1) == 0) ? int'(trials_done) + 2 : 0;
        write_reg(CFG_DEGREE, 16'(final_deg));
        for (int n = 0; n < 8; n++)
            push_word(draw_word(), 1'b0, 2'd0, 32'd0, 32'd0, 1'b0);
        settle();
        write_reg(CFG_DEGREE, 16'hFFFF);
        for (int n = 0; n < 3; n++)
            push_word(draw_word(), 1'b0, 2'd0, 32'd0, 32'd0, 1'b0);
        settle();

        if (edges_due.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", edges_due.size()));
        $display("Sent %0d items over 13 setups; checked %0d results, %0d trials, %0d done.",
                 items_in, results_ok, trials_done, dones_seen);
        $display("Closing budget setting %0d; idle patterns none, sender, receiver and both.",
                 final_deg);
        if (errors == 0) begin
            $display("rmat_edge_generator_unit: match");
        end else begin
            $display("rmat_edge_generator_unit: mismatch");
        end
        $finish;
    end

endmodule

### rmat_edge_generator_unit.f
src/rmat_pkg.sv
src/rmat_mod.sv
src/rmat_ctrl.sv
src/rmat_dpath.sv
src/rmat_edge_generator_unit.sv
src/rmat_checker.sv
test/tb_rmat_edge_generator_unit.sv
